// ===== hw/rtl/fmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Fuzzy membership unit package
// Transfer types, shape codes and fixed-point constants shared by the unit.
// ----------------------------------------------------------------------------
package fmu_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int FRAC_BITS   = 15;
   localparam int DEGREE_BITS = 16;
   localparam int DIFF_W      = VALUE_BITS + 1;
   localparam int DIV_STEP    = 2;
   localparam int DIV_STAGES  = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;

   localparam logic [1:0] FUNC_RAMP      = 2'd0;
   localparam logic [1:0] FUNC_TRIANGLE  = 2'd1;
   localparam logic [1:0] FUNC_TRAPEZOID = 2'd2;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [VALUE_BITS-1:0] value;
      logic signed [VALUE_BITS-1:0] bp0;
      logic signed [VALUE_BITS-1:0] bp1;
      logic signed [VALUE_BITS-1:0] bp2;
      logic signed [VALUE_BITS-1:0] bp3;
   } req_type;

   typedef struct packed {
      logic [DEGREE_BITS-1:0] degree;
      logic                   clamped;
   } rsp_type;

   function automatic logic [DEGREE_BITS-1:0] to_degree(input logic one,
                                                        input logic [FRAC_BITS-1:0] quot);
      logic [FRAC_BITS:0]             full;
      logic [FRAC_BITS+DEGREE_BITS:0] wide;
      full = one ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quot};
      wide = {{DEGREE_BITS{1'b0}}, full};
      return wide[DEGREE_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/fuzzy_membership_unit.sv =====
// ----------------------------------------------------------------------------
// Fuzzy membership unit
// Evaluates one ramp, triangle or trapezoid membership degree per transfer.
//
// The unit takes one request per clock unless back-pressure from the response
// side stalls it, and returns one response per request, in order. The depth
// is set by the restoring divider on the slopes, which retires up to two
// quotient bits per pipeline stage; shape selection, sign handling and
// range checks take three stages ahead of it and the response register one.
// Each stage holds when the stage after it is full and stalled, so a busy
// or idle response side never drops or repeats an item.
// ----------------------------------------------------------------------------
module fuzzy_membership_unit
   import fmu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic                     fixed;
      logic                     one;
      logic signed [DIFF_W-1:0] num;
      logic signed [DIFF_W-1:0] den;
   } sel_type;

   typedef struct packed {
      logic              fixed;
      logic              one;
      logic              flag;
      logic [DIFF_W-1:0] an;
      logic [DIFF_W-1:0] ad;
   } mag_type;

   typedef struct packed {
      logic                 bypass;
      logic                 one;
      logic                 flag;
      logic [DIFF_W-1:0]    rem;
      logic [DIFF_W-1:0]    den;
      logic [FRAC_BITS-1:0] quot;
   } div_type;

   localparam logic [DEGREE_BITS-1:0] DEGREE_ONE = to_degree(1'b1, '0);

   logic                     s1_vld_ff;
   logic                     s2_vld_ff;
   logic                     rsp_valid_ff;
   logic                     s1_rdy;
   logic                     s2_rdy;
   logic                     out_rdy;
   sel_type                  s1_in;
   sel_type                  s1_ff;
   mag_type                  s2_in;
   mag_type                  s2_ff;
   rsp_type                  rsp_data_in;
   rsp_type                  rsp_data_ff;
   div_type                  div_in     [0:DIV_STAGES];
   div_type                  div_ff     [0:DIV_STAGES];
   logic                     div_vld_ff [0:DIV_STAGES];
   logic                     div_rdy    [0:DIV_STAGES];
   logic signed [DIFF_W-1:0] v_x;
   logic signed [DIFF_W-1:0] b0_x;
   logic signed [DIFF_W-1:0] b1_x;
   logic signed [DIFF_W-1:0] b2_x;
   logic signed [DIFF_W-1:0] b3_x;

   assign out_rdy = !rsp_valid_ff || rsp_ready;
   assign s2_rdy  = !s2_vld_ff || div_rdy[0];
   assign s1_rdy  = !s1_vld_ff || s2_rdy;

   assign req_ready = s1_rdy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign v_x  = {req_data.value[VALUE_BITS-1], req_data.value};
   assign b0_x = {req_data.bp0[VALUE_BITS-1], req_data.bp0};
   assign b1_x = {req_data.bp1[VALUE_BITS-1], req_data.bp1};
   assign b2_x = {req_data.bp2[VALUE_BITS-1], req_data.bp2};
   assign b3_x = {req_data.bp3[VALUE_BITS-1], req_data.bp3};

   // shape selection: pick a fixed degree or the slope numerator and divisor
   always_comb begin
      s1_in       = '0;
      s1_in.fixed = 1'b1;
      case (req_data.func)
         FUNC_RAMP: begin
            if (v_x <= b0_x) begin
               s1_in.one = 1'b0;
            end else if (v_x > b1_x) begin
               s1_in.one = 1'b1;
            end else begin
               s1_in.fixed = 1'b0;
               s1_in.num   = v_x - b0_x;
               s1_in.den   = b1_x - b0_x;
            end
         end
         FUNC_TRIANGLE: begin
            if (v_x <= b0_x || v_x >= b2_x) begin
               s1_in.one = 1'b0;
            end else if (v_x == b1_x) begin
               s1_in.one = 1'b1;
            end else if (v_x < b1_x) begin
               s1_in.fixed = 1'b0;
               s1_in.num   = v_x - b0_x;
               s1_in.den   = b1_x - b0_x;
            end else begin
               s1_in.fixed = 1'b0;
               s1_in.num   = b2_x - v_x;
               s1_in.den   = b2_x - b1_x;
            end
         end
         FUNC_TRAPEZOID: begin
            if (v_x <= b0_x || v_x >= b3_x) begin
               s1_in.one = 1'b0;
            end else if (v_x >= b1_x && v_x <= b2_x) begin
               s1_in.one = 1'b1;
            end else if (v_x < b1_x) begin
               s1_in.fixed = 1'b0;
               s1_in.num   = v_x - b0_x;
               s1_in.den   = b1_x - b0_x;
            end else begin
               s1_in.fixed = 1'b0;
               s1_in.num   = b3_x - v_x;
               s1_in.den   = b3_x - b2_x;
            end
         end
         default: begin
            s1_in.one = 1'b0;
         end
      endcase
   end

   // sign checks and magnitudes
   always_comb begin
      s2_in.fixed = s1_ff.fixed;
      s2_in.one   = s1_ff.one;
      s2_in.flag  = 1'b0;
      s2_in.an    = s1_ff.num[DIFF_W-1] ? (~s1_ff.num + DIFF_W'(1)) : s1_ff.num;
      s2_in.ad    = s1_ff.den[DIFF_W-1] ? (~s1_ff.den + DIFF_W'(1)) : s1_ff.den;
      if (!s1_ff.fixed) begin
         if (s1_ff.den == '0) begin
            s2_in.fixed = 1'b1;
            s2_in.one   = 1'b0;
            s2_in.flag  = 1'b1;
         end else if (s1_ff.num == '0) begin
            s2_in.fixed = 1'b1;
            s2_in.one   = 1'b0;
         end else if (s1_ff.num[DIFF_W-1] != s1_ff.den[DIFF_W-1]) begin
            s2_in.fixed = 1'b1;
            s2_in.one   = 1'b0;
            s2_in.flag  = 1'b1;
         end
      end
   end

   // range check and divider entry
   always_comb begin
      div_in[0].bypass = s2_ff.fixed;
      div_in[0].one    = s2_ff.one;
      div_in[0].flag   = s2_ff.flag;
      div_in[0].rem    = s2_ff.an;
      div_in[0].den    = s2_ff.ad;
      div_in[0].quot   = '0;
      if (!s2_ff.fixed) begin
         if (s2_ff.an > s2_ff.ad) begin
            div_in[0].bypass = 1'b1;
            div_in[0].one    = 1'b1;
            div_in[0].flag   = 1'b1;
         end else if (s2_ff.an == s2_ff.ad) begin
            div_in[0].bypass = 1'b1;
            div_in[0].one    = 1'b1;
         end
      end
   end

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div_step
      always_comb begin : step_comb
         logic [DIFF_W:0] shifted;
         div_type         nxt;
         shifted = '0;
         nxt     = div_ff[i];
         for (int j = 0; j < DIV_STEP; j++) begin
            if (i * DIV_STEP + j < FRAC_BITS) begin
               shifted  = {nxt.rem, 1'b0};
               nxt.quot = {nxt.quot[FRAC_BITS-2:0], 1'b0};
               if (shifted >= {1'b0, nxt.den}) begin
                  shifted     = shifted - {1'b0, nxt.den};
                  nxt.quot[0] = 1'b1;
               end
               nxt.rem = shifted[DIFF_W-1:0];
            end
         end
         div_in[i+1] = nxt;
      end
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_div_reg
      if (k == DIV_STAGES) begin : g_last
         assign div_rdy[k] = !div_vld_ff[k] || out_rdy;
      end else begin : g_mid
         assign div_rdy[k] = !div_vld_ff[k] || div_rdy[k+1];
      end

      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[k] <= 1'b0;
            end else if (div_rdy[k]) begin
               div_vld_ff[k] <= s2_vld_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (div_rdy[k] && s2_vld_ff) begin
               div_ff[k] <= div_in[k];
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[k] <= 1'b0;
            end else if (div_rdy[k]) begin
               div_vld_ff[k] <= div_vld_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (div_rdy[k] && div_vld_ff[k-1]) begin
               div_ff[k] <= div_in[k];
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.degree  = to_degree(div_ff[DIV_STAGES].one,
                                      div_ff[DIV_STAGES].bypass ? '0 : div_ff[DIV_STAGES].quot);
      rsp_data_in.clamped = div_ff[DIV_STAGES].flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (out_rdy) begin
            rsp_valid_ff <= div_vld_ff[DIV_STAGES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_rdy && s1_vld_ff) begin
         s2_ff <= s2_in;
      end
      if (out_rdy && div_vld_ff[DIV_STAGES]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_req_enters_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_vld_ff)
      else $error("accepted request did not reach the first stage");

   a_div_tail_holds: assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[DIV_STAGES] && !div_rdy[DIV_STAGES]
      |=> div_vld_ff[DIV_STAGES] && $stable(div_ff[DIV_STAGES]))
      else $error("divider tail changed while stalled");

   for (genvar r = 0; r <= DIV_STAGES; r++) begin : g_rem_chk
      a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
         div_vld_ff[r] && !div_ff[r].bypass |-> div_ff[r].rem < div_ff[r].den)
         else $error("partial remainder not below divisor");
   end

   a_clamp_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamped
      |-> rsp_data.degree == '0 || rsp_data.degree == DEGREE_ONE)
      else $error("clamped response not saturated");

endmodule

// ===== verif/tb_fuzzy_membership_unit.sv =====
// ----------------------------------------------------------------------------
// Fuzzy membership unit testbench
// Runs a table of directed membership queries, then random ramp, triangle,
// trapezoid and unused-code queries under three idling regimes on the request
// and response sides. Every response is checked field by field, in order, against
// degrees computed in the bench from the shape rules, or typed into the table.
// ----------------------------------------------------------------------------
module tb_fuzzy_membership_unit
   import fmu_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]             FUNC_UNUSED = 2'd3;
   localparam logic [DEGREE_BITS-1:0] DEGREE_ONE  = 16'h8000;
   localparam int VALUE_MIN   = -(1 << (VALUE_BITS - 1));
   localparam int VALUE_MAX   = (1 << (VALUE_BITS - 1)) - 1;
   localparam int LATENCY     = 4 + DIV_STAGES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [VALUE_BITS-1:0] value;
      logic signed [VALUE_BITS-1:0] bp0;
      logic signed [VALUE_BITS-1:0] bp1;
      logic signed [VALUE_BITS-1:0] bp2;
      logic signed [VALUE_BITS-1:0] bp3;
      logic                         typed;
      logic [DEGREE_BITS-1:0]       degree;
      logic                         clamped;
   } directed_row_type;

   // func, value, bp0, bp1, bp2, bp3, typed, degree, clamped
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{FUNC_UNUSED,    32767, -32768,  32767, -32768,  32767, 1'b1, 16'd0,      1'b0},
      '{FUNC_UNUSED,        0,      0,      0,      0,      0, 1'b1, 16'd0,      1'b0},
      '{FUNC_RAMP,     -32768, -32768,      0,      0,      0, 1'b1, 16'd0,      1'b0},
      '{FUNC_RAMP,      32767, -32768,  32766,      0,      0, 1'b1, DEGREE_ONE, 1'b0},
      '{FUNC_RAMP,      32767, -32768,  32767,      0,      0, 1'b1, DEGREE_ONE, 1'b0},
      '{FUNC_RAMP,     -32767, -32768,  32767,     -1,     -1, 1'b0, 16'd0,      1'b0},
      '{FUNC_RAMP,         50,      0,    100,  32767, -32768, 1'b0, 16'd0,      1'b0},
      '{FUNC_RAMP,         10,      0,    -10,      0,      0, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,     -5,     -5,      0,      5,      0, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,      5,     -5,      0,      5,      0, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,      0,     -5,      0,      5, -32768, 1'b1, DEGREE_ONE, 1'b0},
      '{FUNC_TRIANGLE,     -2,     -5,      0,      5,  32767, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,      3,     -5,      0,      5,      0, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,  32766, -32768,      0,  32767,      0, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRIANGLE, -32767, -32768,  32767, -32768,     -1, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRIANGLE,      0,     10,      0,    -10,      0, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID, -32768, -32768,  -100,    100,  32767, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,  32767, -32768,  -100,    100,  32767, 1'b1, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,   -100, -32768,  -100,    100,  32767, 1'b1, DEGREE_ONE, 1'b0},
      '{FUNC_TRAPEZOID,    100, -32768,  -100,    100,  32767, 1'b1, DEGREE_ONE, 1'b0},
      '{FUNC_TRAPEZOID,   -101, -32768,  -100,    100,  32767, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,    101, -32768,  -100,    100,  32767, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,      0,    -10,     20,    -20,     10, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,     25,    -10,     20,    -20,     30, 1'b0, 16'd0,      1'b0},
      '{FUNC_TRAPEZOID,  32766, -32768, -32768, -32768,  32767, 1'b0, 16'd0,      1'b0}
   };

   localparam int SENDER_IDLE_PCT   [3] = '{14, 82, 0};
   localparam int RECEIVER_IDLE_PCT [3] = '{82, 14, 0};
   localparam int PHASE_ITEMS       [3] = '{700, 700, 600};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_degrees [$];
   rsp_type offered_result;
   int      sender_idle_pct   = SENDER_IDLE_PCT[0];
   int      receiver_idle_pct = RECEIVER_IDLE_PCT[0];
   int      mismatch_count    = 0;
   int      cycle_count       = 0;

   fuzzy_membership_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Truncated num/den with FRAC_BITS fraction bits, clamped to 0..1.
   function automatic longint slope_fraction(input longint num, input longint den,
                                             output logic clipped);
      longint one;
      longint an;
      longint ad;
      longint rem;
      longint quot;
      one     = longint'(1) << FRAC_BITS;
      clipped = 1'b0;
      if (den == 0) begin
         clipped = 1'b1;
         return 0;
      end
      if (num == 0) return 0;
      if ((num < 0) != (den < 0)) begin
         clipped = 1'b1;
         return 0;
      end
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      if (an > ad) begin
         clipped = 1'b1;
         return one;
      end
      if (an == ad) return one;
      quot = 0;
      rem  = an;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= ad) begin
            rem  = rem - ad;
            quot = quot | 1;
         end
      end
      return quot;
   endfunction

   function automatic rsp_type predict_membership(input req_type q);
      longint  one;
      longint  v;
      longint  x0;
      longint  x1;
      longint  x2;
      longint  x3;
      longint  deg;
      logic    clipped;
      rsp_type r;
      one     = longint'(1) << FRAC_BITS;
      v       = longint'(q.value);
      x0      = longint'(q.bp0);
      x1      = longint'(q.bp1);
      x2      = longint'(q.bp2);
      x3      = longint'(q.bp3);
      deg     = 0;
      clipped = 1'b0;
      case (q.func)
         FUNC_RAMP: begin
            if (v <= x0) deg = 0;
            else if (v > x1) deg = one;
            else deg = slope_fraction(v - x0, x1 - x0, clipped);
         end
         FUNC_TRIANGLE: begin
            if (v <= x0 || v >= x2) deg = 0;
            else if (v == x1) deg = one;
            else if (v < x1) deg = slope_fraction(v - x0, x1 - x0, clipped);
            else deg = slope_fraction(x2 - v, x2 - x1, clipped);
         end
         FUNC_TRAPEZOID: begin
            if (v <= x0 || v >= x3) deg = 0;
            else if (v >= x1 && v <= x2) deg = one;
            else if (v < x1) deg = slope_fraction(v - x0, x1 - x0, clipped);
            else deg = slope_fraction(x3 - v, x3 - x2, clipped);
         end
         default: begin
            deg = 0;
         end
      endcase
      r.degree  = deg[DEGREE_BITS-1:0];
      r.clamped = clipped;
      return r;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] clip_value(input int x);
      if (x < VALUE_MIN) return VALUE_BITS'(VALUE_MIN);
      if (x > VALUE_MAX) return VALUE_BITS'(VALUE_MAX);
      return VALUE_BITS'(x);
   endfunction

   function automatic int random_value();
      return int'($urandom_range(VALUE_MAX - VALUE_MIN)) + VALUE_MIN;
   endfunction

   // Mostly ordered breakpoints, a share of them narrow, plus out-of-order noise.
   function automatic req_type make_query();
      req_type q;
      int      pts [$];
      int      base;
      int      lo;
      int      hi;
      int      top;
      int      roll;
      int      spread;
      roll = $urandom_range(99);
      if (roll < 8) q.func = FUNC_UNUSED;
      else if (roll < 38) q.func = FUNC_RAMP;
      else if (roll < 69) q.func = FUNC_TRIANGLE;
      else q.func = FUNC_TRAPEZOID;
      spread = $urandom_range(99);
      base   = random_value();
      for (int k = 0; k < 4; k++) begin
         if (spread < 30) pts.push_back(int'(clip_value(base + int'($urandom_range(16)))));
         else pts.push_back(random_value());
      end
      if (spread < 88) pts.sort();
      q.bp0 = VALUE_BITS'(pts[0]);
      q.bp1 = VALUE_BITS'(pts[1]);
      q.bp2 = VALUE_BITS'(pts[2]);
      q.bp3 = VALUE_BITS'(pts[3]);
      top = (q.func == FUNC_RAMP) ? 1 : (q.func == FUNC_TRIANGLE) ? 2 : 3;
      lo  = pts[0];
      hi  = pts[top];
      if (lo > hi) begin
         lo = pts[top];
         hi = pts[0];
      end
      lo   = int'(clip_value(lo - 1));
      hi   = int'(clip_value(hi + 1));
      roll = $urandom_range(99);
      if (roll < 25) q.value = VALUE_BITS'(random_value());
      else if (roll < 70) q.value = VALUE_BITS'(lo + int'($urandom_range(hi - lo)));
      else q.value = clip_value(pts[$urandom_range(3)] + int'($urandom_range(2)) - 1);
      if ($urandom_range(1) == 0) begin
         if (q.func == FUNC_RAMP) q.bp2 = VALUE_BITS'(random_value());
         if (q.func != FUNC_TRAPEZOID) q.bp3 = VALUE_BITS'(random_value());
      end
      return q;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_query(input req_type q, input rsp_type result);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      offered_result = result;
      req_valid     <= 1'b1;
      req_data      <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_degrees.size() == 0) begin
               report_mismatch($sformatf("unexpected response degree %0d clamped %0b",
                                         rsp_data.degree, rsp_data.clamped));
            end else begin
               want = expected_degrees.pop_front();
               if (rsp_data.degree !== want.degree)
                  report_mismatch($sformatf("degree got %0d expected %0d",
                                            rsp_data.degree, want.degree));
               if (rsp_data.clamped !== want.clamped)
                  report_mismatch($sformatf("clamped got %0b expected %0b",
                                            rsp_data.clamped, want.clamped));
            end
         end
         if (req_valid && req_ready) expected_degrees.push_back(offered_result);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      req_type          q;
      rsp_type          typed_result;
      directed_row_type row;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i]) begin
         row     = DIRECTED_ROWS[i];
         q.func  = row.func;
         q.value = row.value;
         q.bp0   = row.bp0;
         q.bp1   = row.bp1;
         q.bp2   = row.bp2;
         q.bp3   = row.bp3;
         typed_result.degree  = row.degree;
         typed_result.clamped = row.clamped;
         send_query(q, row.typed ? typed_result : predict_membership(q));
      end
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = SENDER_IDLE_PCT[phase];
         receiver_idle_pct = RECEIVER_IDLE_PCT[phase];
         for (int n = 0; n < PHASE_ITEMS[phase]; n++) begin
            q = make_query();
            send_query(q, predict_membership(q));
         end
      end
      req_valid <= 1'b0;
      while (expected_degrees.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== fuzzy_membership_unit.f =====
hw/rtl/fmu_pkg.sv
hw/rtl/fuzzy_membership_unit.sv
verif/tb_fuzzy_membership_unit.sv
